// ----- hdl/ptlc_pkg.sv -----
// ----------------------------------------------------------------------------
// Pedestrian traffic light controller package
// Shared types, constants and a helper function for the sequencer.
// ----------------------------------------------------------------------------
package ptlc_pkg;

  localparam int COUNT_BITS = 10;
  localparam int REG_W      = 10;
  localparam int LAMP_W     = 5;
  localparam int CODE_W     = 3;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;

  localparam logic [REG_W-1:0] WAIT_RST   = REG_W'(40);
  localparam logic [REG_W-1:0] YELLOW_RST = REG_W'(12);
  localparam logic [REG_W-1:0] RED_RST    = REG_W'(8);
  localparam logic [REG_W-1:0] CROSS_RST  = REG_W'(40);
  localparam logic [REG_W-1:0] RETURN_RST = REG_W'(20);

  localparam logic [2:0] REG_WAIT   = 3'd0;
  localparam logic [2:0] REG_YELLOW = 3'd1;
  localparam logic [2:0] REG_RED    = 3'd2;
  localparam logic [2:0] REG_CROSS  = 3'd3;
  localparam logic [2:0] REG_RETURN = 3'd4;

  localparam logic KIND_BUTTON = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  localparam logic [CODE_W-1:0] P_IDLE   = 3'd0;
  localparam logic [CODE_W-1:0] P_WAIT   = 3'd1;
  localparam logic [CODE_W-1:0] P_YELLOW = 3'd2;
  localparam logic [CODE_W-1:0] P_RED    = 3'd3;
  localparam logic [CODE_W-1:0] P_CROSS  = 3'd4;
  localparam logic [CODE_W-1:0] P_CHECK  = 3'd5;
  localparam logic [CODE_W-1:0] P_RETURN = 3'd6;

  localparam logic [LAMP_W-1:0] L_MAIN_GREEN  = 5'b00001;
  localparam logic [LAMP_W-1:0] L_MAIN_YELLOW = 5'b00010;
  localparam logic [LAMP_W-1:0] L_MAIN_RED    = 5'b00100;
  localparam logic [LAMP_W-1:0] L_CROSS_GREEN = 5'b01000;
  localparam logic [LAMP_W-1:0] L_CROSS_RED   = 5'b10000;

  typedef enum logic [6:0] {
    PH_IDLE   = 7'b0000001,
    PH_WAIT   = 7'b0000010,
    PH_YELLOW = 7'b0000100,
    PH_RED    = 7'b0001000,
    PH_CROSS  = 7'b0010000,
    PH_CHECK  = 7'b0100000,
    PH_RETURN = 7'b1000000
  } phase_e;

  typedef struct packed {
    phase_e                phase;
    logic [COUNT_BITS-1:0] count;
    logic                  request;
    logic                  start_held;
    logic                  stop_held;
    logic [LAMP_W-1:0]     lamps;
  } state_t;

  typedef struct packed {
    logic [REG_W-1:0] wait_ticks;
    logic [REG_W-1:0] yellow_ticks;
    logic [REG_W-1:0] all_red_ticks;
    logic [REG_W-1:0] cross_green_ticks;
    logic [REG_W-1:0] return_ticks;
  } cfg_t;

  typedef struct packed {
    logic kind;
    logic start_pressed;
    logic stop_pressed;
  } item_t;

  function automatic logic [CODE_W-1:0] phase_code(phase_e ph);
    logic [CODE_W-1:0] code;
    unique case (ph)
      PH_IDLE:   code = P_IDLE;
      PH_WAIT:   code = P_WAIT;
      PH_YELLOW: code = P_YELLOW;
      PH_RED:    code = P_RED;
      PH_CROSS:  code = P_CROSS;
      PH_CHECK:  code = P_CHECK;
      default:   code = P_RETURN;
    endcase
    return code;
  endfunction

endpackage

// ----- hdl/ptlc_step.sv -----
// ----------------------------------------------------------------------------
// Pedestrian traffic light controller next-state logic
// Computes the state after one button sample or timer tick.
// ----------------------------------------------------------------------------
module ptlc_step import ptlc_pkg::*; (
  input  state_t cur_i,
  input  cfg_t   cfg_i,
  input  item_t  item_i,
  output state_t nxt_o
);

  state_t                nxt;
  logic                  timed_en;
  logic [COUNT_BITS-1:0] dur;
  logic [COUNT_BITS-1:0] cnt_inc;
  phase_e                timed_next;

  always_comb begin
    nxt        = cur_i;
    timed_en   = 1'b0;
    dur        = '0;
    timed_next = cur_i.phase;
    cnt_inc    = cur_i.count + COUNT_BITS'(1);
    if (item_i.kind == KIND_BUTTON) begin
      if (item_i.start_pressed && !cur_i.start_held) begin
        nxt.request = 1'b1;
      end
      nxt.start_held = item_i.start_pressed;
      if (item_i.stop_pressed && !cur_i.stop_held) begin
        nxt.request = 1'b0;
      end
      nxt.stop_held = item_i.stop_pressed;
    end else begin
      unique case (cur_i.phase)
        PH_IDLE: begin
          nxt.lamps = (cur_i.lamps & ~L_MAIN_RED) | L_CROSS_RED | L_MAIN_GREEN;
          nxt.phase = cur_i.request ? PH_WAIT : PH_IDLE;
          nxt.count = '0;
        end
        PH_WAIT: begin
          timed_en   = 1'b1;
          dur        = COUNT_BITS'(cfg_i.wait_ticks);
          timed_next = PH_YELLOW;
        end
        PH_YELLOW: begin
          nxt.lamps  = (cur_i.lamps & ~L_MAIN_GREEN) | L_MAIN_YELLOW;
          timed_en   = 1'b1;
          dur        = COUNT_BITS'(cfg_i.yellow_ticks);
          timed_next = PH_RED;
        end
        PH_RED: begin
          nxt.lamps  = (cur_i.lamps & ~L_MAIN_YELLOW) | L_MAIN_RED;
          timed_en   = 1'b1;
          dur        = COUNT_BITS'(cfg_i.all_red_ticks);
          timed_next = PH_CROSS;
        end
        PH_CROSS: begin
          nxt.lamps  = (cur_i.lamps & ~L_CROSS_RED) | L_CROSS_GREEN;
          timed_en   = 1'b1;
          dur        = COUNT_BITS'(cfg_i.cross_green_ticks);
          timed_next = PH_CHECK;
        end
        PH_CHECK: begin
          nxt.phase = cur_i.request ? PH_IDLE : PH_RETURN;
        end
        default: begin
          nxt.lamps  = (cur_i.lamps & ~L_CROSS_GREEN) | L_CROSS_RED;
          timed_en   = 1'b1;
          dur        = COUNT_BITS'(cfg_i.return_ticks);
          timed_next = PH_IDLE;
        end
      endcase
      if (timed_en) begin
        nxt.count = cnt_inc;
        if (cnt_inc == dur) begin
          nxt.phase = timed_next;
          nxt.count = '0;
        end
      end
    end
  end

  assign nxt_o = nxt;

endmodule

// ----- hdl/pedestrian_traffic_light_controller_top.sv -----
// ----------------------------------------------------------------------------
// Pedestrian traffic light controller top level
// Streaming sequencer for a two-road crossing with a pedestrian request.
// ----------------------------------------------------------------------------
// Each request on the slave stream is a button sample (tuser low) or a timer
// tick (tuser high). A button sample sets the service request on a start
// press edge and clears it on a stop press edge. A tick advances the
// seven-phase sequencer. Every request yields exactly one result on the
// master stream with the lamp bits, the phase code and the request flag.
// Requests pass through an input register and then a result register, so a
// result is presented on the master stream only after both have been loaded,
// and one request is accepted every cycle while the receiver takes results.
// When the receiver stalls, the result register holds its value and the
// input register still takes one more request before tready falls.
// Durations are set through the APB port; the user must write them only while
// the stream is idle, which the block does not enforce. Reads return the stored
// values. Reset clears the sequencer to the idle phase with all lamps off, no
// request pending and both buttons released, and restores the default durations.
// ----------------------------------------------------------------------------
module pedestrian_traffic_light_controller_top import ptlc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [0] start_pressed, [1] stop_pressed
  input  logic                   s_axis_tuser,   // [0] kind
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [4:0] lamps, [7:5] phase, [8] request
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [DATA_W-1:0]      pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  cfg_t   cfg_q, cfg_d;
  state_t state_q, state_nxt;
  logic   in_valid_q, in_valid_d;
  item_t  in_item_q, in_item_d;
  logic   out_valid_q, out_valid_d;
  logic [LAMP_W-1:0] out_lamps_q, out_lamps_d;
  logic [CODE_W-1:0] out_phase_q, out_phase_d;
  logic   out_req_q, out_req_d;
  logic   advance;
  logic   load_out;
  logic   cfg_wr;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (reg_idx)
        REG_WAIT:   cfg_d.wait_ticks        = pwdata[REG_W-1:0];
        REG_YELLOW: cfg_d.yellow_ticks      = pwdata[REG_W-1:0];
        REG_RED:    cfg_d.all_red_ticks     = pwdata[REG_W-1:0];
        REG_CROSS:  cfg_d.cross_green_ticks = pwdata[REG_W-1:0];
        REG_RETURN: cfg_d.return_ticks      = pwdata[REG_W-1:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WAIT:   prdata = DATA_W'(cfg_q.wait_ticks);
      REG_YELLOW: prdata = DATA_W'(cfg_q.yellow_ticks);
      REG_RED:    prdata = DATA_W'(cfg_q.all_red_ticks);
      REG_CROSS:  prdata = DATA_W'(cfg_q.cross_green_ticks);
      REG_RETURN: prdata = DATA_W'(cfg_q.return_ticks);
      default:    prdata = '0;
    endcase
  end

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign load_out      = in_valid_q && advance;

  always_comb begin
    in_valid_d = s_axis_tready ? s_axis_tvalid : in_valid_q;
    in_item_d  = in_item_q;
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_d.kind          = s_axis_tuser;
      in_item_d.start_pressed = s_axis_tdata[0];
      in_item_d.stop_pressed  = s_axis_tdata[1];
    end
  end

  ptlc_step u_step (
    .cur_i  (state_q),
    .cfg_i  (cfg_q),
    .item_i (in_item_q),
    .nxt_o  (state_nxt)
  );

  always_comb begin
    out_valid_d = advance ? in_valid_q : out_valid_q;
    out_lamps_d = out_lamps_q;
    out_phase_d = out_phase_q;
    out_req_d   = out_req_q;
    if (load_out) begin
      out_lamps_d = state_nxt.lamps;
      out_phase_d = phase_code(state_nxt.phase);
      out_req_d   = state_nxt.request;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wait_ticks        <= WAIT_RST;
      cfg_q.yellow_ticks      <= YELLOW_RST;
      cfg_q.all_red_ticks     <= RED_RST;
      cfg_q.cross_green_ticks <= CROSS_RST;
      cfg_q.return_ticks      <= RETURN_RST;
      state_q.phase           <= PH_IDLE;
      state_q.count           <= '0;
      state_q.request         <= 1'b0;
      state_q.start_held      <= 1'b0;
      state_q.stop_held       <= 1'b0;
      state_q.lamps           <= '0;
      in_valid_q              <= 1'b0;
      out_valid_q             <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (load_out) begin
        state_q <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    in_item_q   <= in_item_d;
    out_lamps_q <= out_lamps_d;
    out_phase_q <= out_phase_d;
    out_req_q   <= out_req_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_req_q, out_phase_q, out_lamps_q};

  a_count_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == PH_IDLE || state_q.phase == PH_CHECK) |-> state_q.count == '0)
    else $error("tick counter not clear in idle or check phase");

  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled while result register is empty");

  a_hold_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> in_valid_q)
    else $error("pending request dropped during output stall");

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// Pedestrian traffic light controller testbench
// Drives button samples and timer ticks into the sequencer through the slave
// stream, predicts lamps, phase and request flag for every request, and
// checks each result on the master stream in order. Durations are written
// and read back over APB between test phases, including the minimum and
// maximum values. Both stream sides idle at random, the receiver holds off
// once for a long stretch, and the sender pauses once until all results
// have arrived.
// ----------------------------------------------------------------------------
module testbench import ptlc_pkg::*; ();

  localparam int LATENCY     = 2;
  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_REGS    = 5;

  typedef struct packed {
    logic [LAMP_W-1:0] lamps;
    logic [2:0]        phase;
    logic              request;
  } lights_t;

  typedef struct packed {
    item_t      req;
    logic [3:0] gap;
  } send_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tuser  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   psel          = 1'b0;
  logic                   penable       = 1'b0;
  logic                   pwrite        = 1'b0;
  logic [ADDR_W-1:0]      paddr         = '0;
  logic [DATA_W-1:0]      pwdata        = '0;
  logic [DATA_W-1:0]      prdata;
  logic                   pready;

  send_t   send_q[$];
  lights_t lights_q[$];

  logic [REG_W-1:0]      dur [NUM_REGS];
  logic [2:0]            lt_phase      = P_IDLE;
  logic [COUNT_BITS-1:0] lt_count      = '0;
  logic                  lt_request    = 1'b0;
  logic                  lt_start_held = 1'b0;
  logic                  lt_stop_held  = 1'b0;
  logic [LAMP_W-1:0]     lt_lamps      = '0;

  int          errors = 0;
  int          cycles = 0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;
  logic        rx_hold = 1'b0;
  int unsigned tx_gap;
  int unsigned rx_wait;
  item_t       cur;
  send_t       nxt;
  lights_t     want;

  pedestrian_traffic_light_controller_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [0] start_pressed, [1] stop_pressed
    .s_axis_tuser  (s_axis_tuser),   // [0] kind
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [4:0] lamps, [7:5] phase, [8] request
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  function automatic void set_lamps(logic [LAMP_W-1:0] clr, logic [LAMP_W-1:0] set);
    lt_lamps = (lt_lamps & ~clr) | set;
  endfunction

  function automatic void count_tick(logic [REG_W-1:0] limit, logic [2:0] next);
    lt_count = lt_count + COUNT_BITS'(1);
    if (lt_count == COUNT_BITS'(limit)) begin
      lt_phase = next;
      lt_count = '0;
    end
  endfunction

  function automatic lights_t advance_lights(item_t it);
    lights_t r;
    if (it.kind == KIND_BUTTON) begin
      if (it.start_pressed && !lt_start_held) lt_request = 1'b1;
      lt_start_held = it.start_pressed;
      if (it.stop_pressed && !lt_stop_held) lt_request = 1'b0;
      lt_stop_held = it.stop_pressed;
    end else begin
      case (lt_phase)
        P_IDLE: begin
          set_lamps(L_MAIN_RED, L_CROSS_RED | L_MAIN_GREEN);
          lt_phase = lt_request ? P_WAIT : P_IDLE;
          lt_count = '0;
        end
        P_WAIT: count_tick(dur[REG_WAIT], P_YELLOW);
        P_YELLOW: begin
          set_lamps(L_MAIN_GREEN, L_MAIN_YELLOW);
          count_tick(dur[REG_YELLOW], P_RED);
        end
        P_RED: begin
          set_lamps(L_MAIN_YELLOW, L_MAIN_RED);
          count_tick(dur[REG_RED], P_CROSS);
        end
        P_CROSS: begin
          set_lamps(L_CROSS_RED, L_CROSS_GREEN);
          count_tick(dur[REG_CROSS], P_CHECK);
        end
        P_CHECK: lt_phase = lt_request ? P_IDLE : P_RETURN;
        default: begin
          set_lamps(L_CROSS_GREEN, L_CROSS_RED);
          count_tick(dur[REG_RETURN], P_IDLE);
        end
      endcase
    end
    r.lamps   = lt_lamps;
    r.phase   = lt_phase;
    r.request = lt_request;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned exp_val);
    $display("mismatch in %s: got 0x%0h, expected 0x%0h, cycle %0d",
             what, got, exp_val, cycles);
    errors++;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) lights_q.push_back(advance_lights(cur));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap != 0) begin
          tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (send_q.size() != 0) begin
          nxt = send_q.pop_front();
          cur = nxt.req;
          tx_gap = 32'(nxt.gap);
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {{(IN_TDATA_W-2){1'b0}}, cur.stop_pressed, cur.start_pressed};
          s_axis_tuser  <= cur.kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (lights_q.size() == 0) begin
          report_mismatch("unexpected result", 32'(m_axis_tdata), 0);
        end else begin
          want = lights_q.pop_front();
          if (m_axis_tdata[4:0] != want.lamps)
            report_mismatch("lamps", 32'(m_axis_tdata[4:0]), 32'(want.lamps));
          if (m_axis_tdata[7:5] != want.phase)
            report_mismatch("phase", 32'(m_axis_tdata[7:5]), 32'(want.phase));
          if (m_axis_tdata[8] != want.request)
            report_mismatch("request", 32'(m_axis_tdata[8]), 32'(want.request));
        end
        rx_wait = rx_calm ? 0 : $urandom_range(0, 8);
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      m_axis_tready <= (rx_wait == 0) && !rx_hold;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[pedestrian_traffic_light_controller_top] ERROR");
      $finish;
    end
  end

  task automatic push(input logic kind, input logic st, input logic sp);
    send_t s;
    s.req.kind          = kind;
    s.req.start_pressed = st;
    s.req.stop_pressed  = sp;
    s.gap               = tx_calm ? 4'd0 : 4'($urandom_range(0, 8));
    send_q.push_back(s);
  endtask

  task automatic push_random(input int n, input int tick_pct);
    for (int i = 0; i < n; i++) begin
      push(($urandom_range(0, 99) < tick_pct) ? KIND_TICK : KIND_BUTTON,
           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    while (send_q.size() != 0 || s_axis_tvalid || lights_q.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic check_reg(input logic [2:0] idx);
    logic [DATA_W-1:0] got;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got[REG_W-1:0] != dur[idx]) report_mismatch("register read", got, 32'(dur[idx]));
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [REG_W-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= DATA_W'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    dur[idx] = val;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    check_reg(idx);
  endtask

  task automatic set_durations(input logic [REG_W-1:0] w, input logic [REG_W-1:0] y,
                               input logic [REG_W-1:0] r, input logic [REG_W-1:0] c,
                               input logic [REG_W-1:0] rt);
    apb_write(REG_WAIT, w);
    apb_write(REG_YELLOW, y);
    apb_write(REG_RED, r);
    apb_write(REG_CROSS, c);
    apb_write(REG_RETURN, rt);
  endtask

  task automatic push_ticks(input int n);
    for (int i = 0; i < n; i++) push(KIND_TICK, 1'b0, 1'b0);
  endtask

  initial begin
    dur[REG_WAIT]   = WAIT_RST;
    dur[REG_YELLOW] = YELLOW_RST;
    dur[REG_RED]    = RED_RST;
    dur[REG_CROSS]  = CROSS_RST;
    dur[REG_RETURN] = RETURN_RST;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < NUM_REGS; i++) check_reg(3'(i));

    // Directed sequence with the shortest durations.
    set_durations(1, 1, 1, 1, 1);
    push(KIND_TICK, 1'b0, 1'b0);
    push(KIND_BUTTON, 1'b1, 1'b0);
    push(KIND_BUTTON, 1'b1, 1'b0);
    push(KIND_BUTTON, 1'b0, 1'b0);
    push(KIND_BUTTON, 1'b1, 1'b1);
    push(KIND_BUTTON, 1'b0, 1'b0);
    push(KIND_BUTTON, 1'b0, 1'b1);
    push(KIND_BUTTON, 1'b1, 1'b0);
    push(KIND_TICK, 1'b1, 1'b1);
    push_ticks(5);
    push(KIND_TICK, 1'b0, 1'b1);
    push_ticks(1);
    push(KIND_BUTTON, 1'b0, 1'b1);
    push(KIND_BUTTON, 1'b0, 1'b0);
    push(KIND_BUTTON, 1'b0, 1'b1);
    push_ticks(6);
    drain();

    // Shortest durations, both sides idling, with a sender pause halfway.
    push_random(85, 70);
    drain();
    push_random(85, 70);
    drain();

    // Short random durations; the receiver holds off while the sender streams.
    set_durations(REG_W'($urandom_range(1, 6)), REG_W'($urandom_range(1, 6)),
                  REG_W'($urandom_range(1, 6)), REG_W'($urandom_range(1, 6)),
                  REG_W'($urandom_range(1, 6)));
    tx_calm = 1'b1;
    push(KIND_BUTTON, 1'b1, 1'b0);
    push_random(170, 75);
    while (send_q.size() > 140) @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (60) @(posedge clk_i);
    rx_hold <= 1'b0;
    drain();

    // Medium durations with a receiver that never stalls.
    set_durations(REG_W'($urandom_range(1, 12)), REG_W'($urandom_range(1, 12)),
                  REG_W'($urandom_range(1, 12)), REG_W'($urandom_range(1, 12)),
                  REG_W'($urandom_range(1, 12)));
    tx_calm = 1'b0;
    rx_calm = 1'b1;
    push_random(170, 70);
    drain();

    // Longest durations: the wait phase runs to the full counter value.
    set_durations(1023, 1023, 1023, 1023, 1023);
    rx_calm = 1'b0;
    push(KIND_BUTTON, 1'b0, 1'b0);
    push(KIND_BUTTON, 1'b1, 1'b0);
    push(KIND_TICK, 1'b0, 1'b0);
    push_random(1150, 98);
    drain();

    repeat (LATENCY + 8) @(posedge clk_i);
    if (errors == 0 && lights_q.size() == 0) begin
      $display("[pedestrian_traffic_light_controller_top] OK");
    end else begin
      $display("[pedestrian_traffic_light_controller_top] ERROR");
    end
    $finish;
  end

endmodule
